[design/http_request_framer_unit_macros.svh]
// ----------------------------------------------------------------------------
// http request framer assertion macros
// shared property shorthands for the checker
// ----------------------------------------------------------------------------
`ifndef HTTP_REQUEST_FRAMER_UNIT_MACROS_SVH
`define HTTP_REQUEST_FRAMER_UNIT_MACROS_SVH

// same-cycle implication
`define HRF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HRF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/hrf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrf_pkg
// types, constants and the header name table of the http request framer
// ----------------------------------------------------------------------------
package hrf_pkg;

  localparam int unsigned LengthWidth = 32;
  localparam int unsigned ParsedLenW  = 32;

  localparam logic [3:0] NameLen = 4'd15;

  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpZ   = 8'h5A;
  localparam logic [7:0] CaseOfs = 8'h20;

  typedef enum logic [1:0] {
    PhName,
    PhBlank,
    PhDigits,
    PhIgnore
  } phase_e;

  typedef enum logic [1:0] {
    CrlfNone,
    CrlfCr,
    CrlfCrLf,
    CrlfCrLfCr
  } crlf_e;

  typedef struct packed {
    logic                  header_end;
    logic                  message_end;
    logic [ParsedLenW-1:0] parsed_length;
    logic                  length_saturated;
  } result_t;

  // lower-case "content-length:"
  function automatic logic [7:0] key_char(input logic [3:0] idx);
    logic [7:0] ch;
    unique case (idx)
      4'd0:    ch = 8'h63;
      4'd1:    ch = 8'h6F;
      4'd2:    ch = 8'h6E;
      4'd3:    ch = 8'h74;
      4'd4:    ch = 8'h65;
      4'd5:    ch = 8'h6E;
      4'd6:    ch = 8'h74;
      4'd7:    ch = 8'h2D;
      4'd8:    ch = 8'h6C;
      4'd9:    ch = 8'h65;
      4'd10:   ch = 8'h6E;
      4'd11:   ch = 8'h67;
      4'd12:   ch = 8'h74;
      4'd13:   ch = 8'h68;
      4'd14:   ch = 8'h3A;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

[design/hrf_stream_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrf_stream_if
// valid/ready channel carrying one request or one result
// ----------------------------------------------------------------------------
interface hrf_stream_if #(
  parameter type payload_t = logic [7:0]
) ();

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

[design/hrf_in_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrf_in_stage
// input register holding the next request byte
// ----------------------------------------------------------------------------
module hrf_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [7:0] in_data_i,
  output logic       in_ready_o,
  input  logic       adv_i,
  output logic       move_o,
  output logic [7:0] byte_o
);

  logic       valid_q;
  logic [7:0] byte_q;
  logic       load;

  assign move_o     = valid_q & adv_i;
  assign in_ready_o = ~valid_q | adv_i;
  assign load       = in_valid_i & in_ready_o;
  assign byte_o     = byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (move_o) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= in_data_i;
    end
  end

endmodule

[design/hrf_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrf_parser
// header scan, content-length decode and body count for one byte
// ----------------------------------------------------------------------------
module hrf_parser #(
  parameter int unsigned LENGTH_WIDTH = hrf_pkg::LengthWidth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             move_i,
  input  logic [7:0]       byte_i,
  output hrf_pkg::result_t res_o
);

  import hrf_pkg::*;

  localparam int unsigned ProdW = LENGTH_WIDTH + 4;

  crlf_e                   crlf_q, crlf_d;
  phase_e                  phase_q, phase_d;
  logic [3:0]              cnt_q, cnt_d, cnt_inc;
  logic                    seen_q, seen_d;
  logic [LENGTH_WIDTH-1:0] len_q, len_d;
  logic                    ovf_q, ovf_d;
  logic                    body_on_q, body_on_d;
  logic [LENGTH_WIDTH-1:0] body_q, body_d;

  logic                    is_digit;
  logic [7:0]              lc;
  logic [ProdW-1:0]        prod;
  logic                    add_ovf;
  logic [LENGTH_WIDTH-1:0] add_val;
  logic                    he, me;
  logic                    eol_hit;

  assign is_digit = (byte_i >= ChZero) && (byte_i <= ChNine);
  assign lc       = ((byte_i >= ChUpA) && (byte_i <= ChUpZ)) ? byte_i + CaseOfs : byte_i;
  assign cnt_inc  = cnt_q + 4'd1;

  // len*10 + digit, wide enough to see a carry past the length width
  assign prod    = ProdW'({len_q, 3'b000}) + ProdW'({len_q, 1'b0})
                 + ProdW'(byte_i[3:0]);
  assign add_ovf = ovf_q | (prod[ProdW-1:LENGTH_WIDTH] != 4'd0);
  assign add_val = add_ovf ? '1 : prod[LENGTH_WIDTH-1:0];

  assign eol_hit = (byte_i == ChLf) && ((crlf_q == CrlfCr) || (crlf_q == CrlfCrLfCr));

  always_comb begin
    crlf_d    = crlf_q;
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    seen_d    = seen_q;
    len_d     = len_q;
    ovf_d     = ovf_q;
    body_on_d = body_on_q;
    body_d    = body_q;
    he        = 1'b0;
    me        = 1'b0;

    if (body_on_q) begin
      body_d = body_q + LENGTH_WIDTH'(1);
      me     = (body_d == len_q);
    end else begin
      unique case (phase_q)
        PhName: begin
          if (seen_q || (cnt_q >= NameLen) || (lc != key_char(cnt_q))) begin
            phase_d = PhIgnore;
          end else begin
            cnt_d = cnt_inc;
            if (cnt_inc == NameLen) begin
              seen_d  = 1'b1;
              len_d   = '0;
              phase_d = PhBlank;
            end
          end
        end
        PhBlank: begin
          if ((byte_i == ChSpace) || (byte_i == ChTab)) begin
            phase_d = PhBlank;
          end else if (is_digit) begin
            len_d   = add_val;
            ovf_d   = add_ovf;
            phase_d = PhDigits;
          end else begin
            phase_d = PhIgnore;
          end
        end
        PhDigits: begin
          if (is_digit) begin
            len_d = add_val;
            ovf_d = add_ovf;
          end else begin
            phase_d = PhIgnore;
          end
        end
        default: phase_d = PhIgnore;
      endcase

      if (eol_hit) begin
        phase_d = PhName;
        cnt_d   = 4'd0;
      end

      if ((crlf_q == CrlfCrLfCr) && (byte_i == ChLf)) begin
        he     = 1'b1;
        crlf_d = CrlfNone;
      end else if ((crlf_q == CrlfNone) && (byte_i == ChCr)) begin
        crlf_d = CrlfCr;
      end else if ((crlf_q == CrlfCrLf) && (byte_i == ChCr)) begin
        crlf_d = CrlfCrLfCr;
      end else if ((crlf_q == CrlfCr) && (byte_i == ChLf)) begin
        crlf_d = CrlfCrLf;
      end else begin
        crlf_d = (byte_i == ChCr) ? CrlfCr : CrlfNone;
      end

      if (he) begin
        body_on_d = 1'b1;
        body_d    = '0;
        me        = (len_d == '0);
      end
    end

    res_o.header_end       = he;
    res_o.message_end      = me;
    res_o.parsed_length    = ParsedLenW'(len_d);
    res_o.length_saturated = ovf_d;

    // message done: back to the reset state
    if (me) begin
      crlf_d    = CrlfNone;
      phase_d   = PhName;
      cnt_d     = 4'd0;
      seen_d    = 1'b0;
      len_d     = '0;
      ovf_d     = 1'b0;
      body_on_d = 1'b0;
      body_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crlf_q    <= CrlfNone;
      phase_q   <= PhName;
      cnt_q     <= 4'd0;
      seen_q    <= 1'b0;
      len_q     <= '0;
      ovf_q     <= 1'b0;
      body_on_q <= 1'b0;
      body_q    <= '0;
    end else if (move_i) begin
      crlf_q    <= crlf_d;
      phase_q   <= phase_d;
      cnt_q     <= cnt_d;
      seen_q    <= seen_d;
      len_q     <= len_d;
      ovf_q     <= ovf_d;
      body_on_q <= body_on_d;
      body_q    <= body_d;
    end
  end

endmodule

[design/hrf_out_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrf_out_stage
// result register between the parser and the result channel
// ----------------------------------------------------------------------------
module hrf_out_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             move_i,
  input  hrf_pkg::result_t res_i,
  output logic             adv_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output hrf_pkg::result_t out_data_o
);

  import hrf_pkg::*;

  logic    valid_q;
  result_t res_q;

  assign adv_o       = ~valid_q | out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_o) begin
      valid_q <= move_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move_i) begin
      res_q <= res_i;
    end
  end

endmodule

[design/http_request_framer_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_request_framer_unit
// frames an http request by header terminator and content-length
// path: a request byte is registered in the input stage, then its result in the output stage
// throughput: one request per cycle while the result channel does not stall
// reset: asynchronous, clears both register valids and all parser state
// ----------------------------------------------------------------------------
module http_request_framer_unit #(
  parameter int unsigned LENGTH_WIDTH = hrf_pkg::LengthWidth
) (
  input logic         clk_i,
  input logic         rst_ni,
  hrf_stream_if.sink   in_i,
  hrf_stream_if.source out_o
);

  import hrf_pkg::*;

  logic       adv;
  logic       move;
  logic       in_ready;
  logic [7:0] cur_byte;
  result_t    res;
  result_t    out_data;
  logic       out_valid;

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;
  assign out_o.data  = out_data;

  hrf_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_data_i  (in_i.data),
    .in_ready_o (in_ready),
    .adv_i      (adv),
    .move_o     (move),
    .byte_o     (cur_byte)
  );

  hrf_parser #(
    .LENGTH_WIDTH (LENGTH_WIDTH)
  ) u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .move_i (move),
    .byte_i (cur_byte),
    .res_o  (res)
  );

  hrf_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .move_i      (move),
    .res_i       (res),
    .adv_o       (adv),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (out_data)
  );

endmodule

[design/hrf_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrf_checker
// port-level checks of the http request framer, bound to the top level
// ----------------------------------------------------------------------------
`include "http_request_framer_unit_macros.svh"

module hrf_checker #(
  parameter int unsigned LENGTH_WIDTH = hrf_pkg::LengthWidth
) (
  input logic         clk_i,
  input logic         rst_ni,
  hrf_stream_if.sink   in_i,
  hrf_stream_if.source out_o
);

  import hrf_pkg::*;

  localparam logic [ParsedLenW-1:0] SatLow = (LENGTH_WIDTH >= ParsedLenW) ? '1 :
    ParsedLenW'((64'd1 << LENGTH_WIDTH) - 64'd1);
  localparam bit NarrowLen = (LENGTH_WIDTH <= ParsedLenW);

  `HRF_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_o.valid && !out_o.ready, out_o.valid && $stable(out_o.data), "result changed while stalled")

  `HRF_ASSERT_NOW(a_zero_len_end, clk_i, rst_ni, out_o.valid && out_o.data.header_end && NarrowLen && (out_o.data.parsed_length == '0), out_o.data.message_end, "zero length without message end")

  `HRF_ASSERT_NOW(a_sat_value, clk_i, rst_ni, out_o.valid && out_o.data.length_saturated, out_o.data.parsed_length == SatLow, "saturated length not clamped")

  `HRF_ASSERT_NOW(a_latency, clk_i, rst_ni, $rose(out_o.valid), $past(in_i.valid && in_i.ready, 2), "result without request two cycles earlier")

endmodule

bind http_request_framer_unit hrf_checker #(
  .LENGTH_WIDTH (LENGTH_WIDTH)
) u_hrf_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .in_i   (in_i),
  .out_o  (out_o)
);
